// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define CHK_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define CHK_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/rsmvp_pkg.sv
// Shared types, constants and reset tables for the rpm step map.
package rsmvp_pkg;

  localparam int STEP_COUNT = 11;
  localparam int SEL_W      = $clog2(STEP_COUNT);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int ADDR_W = 4;

  localparam int RPM_RST_LO   = 3000;
  localparam int RPM_RST_SPAN = 3000;
  localparam int PCT_RST_SPAN = 100;

  localparam logic [9:0]  HYST_RST   = 10'd100;
  localparam logic [9:0]  MARGIN_RST = 10'd100;
  localparam logic [11:0] CLOSED_RST = 12'd1300;
  localparam logic [11:0] OPEN_RST   = 12'd2400;

  localparam int          MAG_W     = 20;
  localparam int          QUO_W     = 40;
  localparam int          DIV_SHIFT = 26;
  localparam int          Q_W       = QUO_W - DIV_SHIFT;
  localparam logic [MAG_W-1:0] DIV_MAGIC = 20'd671089;

  localparam logic [11:0] PULSE_MAX = 12'd4095;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_HYST   = 2'd0,
    REG_MARGIN = 2'd1,
    REG_CLOSED = 2'd2,
    REG_OPEN   = 2'd3
  } reg_t;

  typedef struct packed {
    logic        is_load;
    logic [3:0]  idx;
    logic [15:0] rpm;
    logic [6:0]  pct;
  } q_item_t;

  typedef struct packed {
    logic [9:0]  hyst;
    logic [9:0]  margin;
    logic [11:0] closed_us;
    logic [11:0] open_us;
  } cfg_t;

  typedef logic [STEP_COUNT-1:0][15:0] thr_tab_t;
  typedef logic [STEP_COUNT-1:0][6:0]  pct_tab_t;

  function automatic thr_tab_t thr_rst_init();
    thr_tab_t t;
    for (int k = 0; k < STEP_COUNT; k++) begin
      t[k] = 16'(RPM_RST_LO + (k * RPM_RST_SPAN) / (STEP_COUNT - 1));
    end
    return t;
  endfunction

  function automatic pct_tab_t pct_rst_init();
    pct_tab_t t;
    for (int k = 0; k < STEP_COUNT; k++) begin
      t[k] = 7'((k * PCT_RST_SPAN) / (STEP_COUNT - 1));
    end
    return t;
  endfunction

  localparam thr_tab_t THR_RST = thr_rst_init();
  localparam pct_tab_t PCT_RST = pct_rst_init();

endpackage

// File: hdl/rsmvp_front.sv
// Front end: accept items, classify them and queue them for the back end.
module rsmvp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic                in_opcode,
  input  logic [3:0]          in_entry_index,
  input  logic [15:0]         in_entry_rpm,
  input  logic [6:0]          in_entry_percent,
  input  logic [15:0]         in_engine_rpm,
  input  logic                q_pop,
  output logic                q_empty,
  output rsmvp_pkg::q_item_t  q_item
);
  import rsmvp_pkg::*;

  q_item_t            q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  q_item_t            item_in;
  logic               keep;
  logic               wr;
  logic               rd;

  always_comb begin
    item_in.is_load = (op_t'(in_opcode) == OP_LOAD);
    item_in.idx     = in_entry_index;
    item_in.rpm     = item_in.is_load ? in_entry_rpm : in_engine_rpm;
    item_in.pct     = in_entry_percent;
  end

  // drop loads aimed past the table
  assign keep    = !item_in.is_load || (32'(in_entry_index) < STEP_COUNT);
  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign wr      = push && !full && keep;
  assign rd      = q_pop && !q_empty;
  assign q_item  = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    unique case ({wr, rd})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q_mem_r[wr_ptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: hdl/rsmvp_back.sv
// Back end: table store, band search sequencer, pulse interpolation and result register.
module rsmvp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  rsmvp_pkg::cfg_t     cfg,
  input  logic                q_empty,
  input  rsmvp_pkg::q_item_t  q_item,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output logic [3:0]          out_chosen_index,
  output logic [6:0]          out_open_percent,
  output logic [11:0]         out_pulse_width_us,
  output logic                out_falling
);
  import rsmvp_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_TOP    = 6'b000010,
    ST_SEARCH = 6'b000100,
    ST_APPLY  = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_FIN    = 6'b100000
  } state_t;

  localparam logic [SEL_W-1:0] LAST = SEL_W'(STEP_COUNT - 1);

  state_t              state_r, state_nxt;
  logic [SEL_W-1:0]    k_r, k_nxt;
  logic [SEL_W-1:0]    sel_r, sel_nxt;
  logic [15:0]         speed_r, speed_nxt;
  logic [9:0]          off_r, off_nxt;
  logic [15:0]         prev_r, prev_nxt;
  logic                act_r, act_nxt;
  logic [6:0]          pct_r, pct_nxt;
  logic signed [20:0]  prod_r, prod_nxt;
  logic                neg_r, neg_nxt;
  logic [QUO_W-1:0]    quo_r, quo_nxt;

  logic [15:0]         thr_mem [STEP_COUNT];
  logic [6:0]          pct_mem [STEP_COUNT];
  logic [STEP_COUNT-1:0] vld_r;
  logic [SEL_W-1:0]    rd_addr;
  logic [SEL_W-1:0]    rd_addr_q_r;
  logic [15:0]         rd_thr_r;
  logic [6:0]          rd_pct_r;
  logic                rd_vld_r;
  logic                mem_we;
  logic [SEL_W-1:0]    wa;

  logic [15:0]         cur_thr;
  logic [6:0]          cur_pct;
  logic signed [17:0]  spd_s;
  logic signed [17:0]  top_lim;
  logic signed [17:0]  band_lim;
  logic                top_hit;
  logic                below;
  logic signed [12:0]  diff;
  logic signed [20:0]  mul_a;
  logic signed [20:0]  mul_b;
  logic [MAG_W-1:0]    mag;
  logic [Q_W-1:0]      quo;
  logic signed [14:0]  delta;
  logic signed [14:0]  pulse_sum;
  logic [11:0]         pulse_sat;

  logic                out_vld_r;
  logic                out_load;
  logic [3:0]          out_idx_r;
  logic [6:0]          out_pct_r;
  logic [11:0]         out_pulse_r;
  logic                out_fall_r;

  assign wa      = SEL_W'(q_item.idx);
  assign cur_thr = rd_vld_r ? rd_thr_r : THR_RST[rd_addr_q_r];
  assign cur_pct = rd_vld_r ? rd_pct_r : PCT_RST[rd_addr_q_r];

  assign spd_s    = $signed({2'b00, speed_r});
  assign top_lim  = $signed({2'b00, cur_thr}) - $signed({8'd0, cfg.margin});
  assign band_lim = $signed({2'b00, cur_thr}) - $signed({8'd0, off_r});
  assign top_hit  = (spd_s >= top_lim);
  assign below    = (spd_s < band_lim);

  assign diff  = $signed({1'b0, cfg.open_us}) - $signed({1'b0, cfg.closed_us});
  assign mul_a = $signed({14'd0, cur_pct});
  assign mul_b = $signed({{8{diff[12]}}, diff});
  assign mag   = prod_r[20] ? MAG_W'(-prod_r) : MAG_W'(prod_r);

  assign quo       = quo_r[QUO_W-1:DIV_SHIFT];
  assign delta     = neg_r ? (15'sd0 - $signed({1'b0, quo})) : $signed({1'b0, quo});
  assign pulse_sum = $signed({3'b000, cfg.closed_us}) + delta;

  always_comb begin
    priority if (pulse_sum < 15'sd0) begin
      pulse_sat = '0;
    end else if (pulse_sum > $signed({3'b000, PULSE_MAX})) begin
      pulse_sat = PULSE_MAX;
    end else begin
      pulse_sat = pulse_sum[11:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    sel_nxt   = sel_r;
    speed_nxt = speed_r;
    off_nxt   = off_r;
    prev_nxt  = prev_r;
    act_nxt   = act_r;
    pct_nxt   = pct_r;
    prod_nxt  = prod_r;
    neg_nxt   = neg_r;
    quo_nxt   = quo_r;
    rd_addr   = sel_r;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_item.is_load) begin
            mem_we = 1'b1;
          end else begin
            speed_nxt = q_item.rpm;
            off_nxt   = act_r ? cfg.hyst : '0;
            rd_addr   = LAST;
            k_nxt     = SEL_W'(1);
            state_nxt = ST_TOP;
          end
        end
      end
      ST_TOP: begin
        if (top_hit) begin
          sel_nxt   = LAST;
          rd_addr   = LAST;
          state_nxt = ST_APPLY;
        end else begin
          rd_addr   = k_r;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        priority if (below) begin
          sel_nxt   = k_r - 1'b1;
          rd_addr   = k_r - 1'b1;
          state_nxt = ST_APPLY;
        end else if (k_r == LAST) begin
          sel_nxt   = '0;
          rd_addr   = '0;
          state_nxt = ST_APPLY;
        end else begin
          k_nxt   = k_r + 1'b1;
          rd_addr = k_r + 1'b1;
        end
      end
      ST_APPLY: begin
        priority if (cur_thr < prev_r) begin
          act_nxt = 1'b1;
        end else if (cur_thr > prev_r) begin
          act_nxt = 1'b0;
        end else begin
          act_nxt = act_r;
        end
        prev_nxt  = cur_thr;
        pct_nxt   = cur_pct;
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        neg_nxt   = prod_r[20];
        quo_nxt   = {{(QUO_W-MAG_W){1'b0}}, mag} * {{(QUO_W-MAG_W){1'b0}}, DIV_MAGIC};
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_vld_r || pop) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      thr_mem[wa] <= q_item.rpm;
      pct_mem[wa] <= q_item.pct;
    end
    rd_thr_r    <= thr_mem[rd_addr];
    rd_pct_r    <= pct_mem[rd_addr];
    rd_addr_q_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    sel_r   <= sel_nxt;
    speed_r <= speed_nxt;
    off_r   <= off_nxt;
    pct_r   <= pct_nxt;
    prod_r  <= prod_nxt;
    neg_r   <= neg_nxt;
    quo_r   <= quo_nxt;
    if (out_load) begin
      out_idx_r   <= 4'(sel_r);
      out_pct_r   <= pct_r;
      out_pulse_r <= pulse_sat;
      out_fall_r  <= act_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      vld_r     <= '0;
      rd_vld_r  <= 1'b0;
      prev_r    <= '0;
      act_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= vld_r[rd_addr];
      prev_r   <= prev_nxt;
      act_r    <= act_nxt;
      if (mem_we) begin
        vld_r[wa] <= 1'b1;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign empty              = !out_vld_r;
  assign out_chosen_index   = out_idx_r;
  assign out_open_percent   = out_pct_r;
  assign out_pulse_width_us = out_pulse_r;
  assign out_falling        = out_fall_r;

endmodule

// File: hdl/rpm_step_map_valve_position_top.sv
// Top level: configuration registers, front end and back end of the rpm step map.
// A load item is written to the table store as it is popped. A sample steps through TOP, SEARCH,
// APPLY, DIV and FIN; TOP skips the search when the top band is hit, else SEARCH reads the table
// one entry per cycle. A waiting result stalls the sequencer in FIN.
// Reset (synchronous, rst_n low) empties the queue and result, restores table and registers.
module rpm_step_map_valve_position_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic                         in_opcode,
  input  logic [3:0]                   in_entry_index,
  input  logic [15:0]                  in_entry_rpm,
  input  logic [6:0]                   in_entry_percent,
  input  logic [15:0]                  in_engine_rpm,
  output logic                         empty,
  input  logic                         pop,
  output logic [3:0]                   out_chosen_index,
  output logic [6:0]                   out_open_percent,
  output logic [11:0]                  out_pulse_width_us,
  output logic                         out_falling,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rsmvp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import rsmvp_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_t     reg_sel;
  logic     cfg_we;
  logic     q_pop;
  logic     q_empty;
  q_item_t  q_item;

  assign pready  = 1'b1;
  assign reg_sel = reg_t'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_sel)
        REG_HYST:   cfg_nxt.hyst      = pwdata[9:0];
        REG_MARGIN: cfg_nxt.margin    = pwdata[9:0];
        REG_CLOSED: cfg_nxt.closed_us = pwdata[11:0];
        REG_OPEN:   cfg_nxt.open_us   = pwdata[11:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_HYST:   prdata = {22'd0, cfg_r.hyst};
      REG_MARGIN: prdata = {22'd0, cfg_r.margin};
      REG_CLOSED: prdata = {20'd0, cfg_r.closed_us};
      REG_OPEN:   prdata = {20'd0, cfg_r.open_us};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hyst      <= HYST_RST;
      cfg_r.margin    <= MARGIN_RST;
      cfg_r.closed_us <= CLOSED_RST;
      cfg_r.open_us   <= OPEN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rsmvp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_opcode        (in_opcode),
    .in_entry_index   (in_entry_index),
    .in_entry_rpm     (in_entry_rpm),
    .in_entry_percent (in_entry_percent),
    .in_engine_rpm    (in_engine_rpm),
    .q_pop            (q_pop),
    .q_empty          (q_empty),
    .q_item           (q_item)
  );

  rsmvp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_empty            (q_empty),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .pop                (pop),
    .empty              (empty),
    .out_chosen_index   (out_chosen_index),
    .out_open_percent   (out_open_percent),
    .out_pulse_width_us (out_pulse_width_us),
    .out_falling        (out_falling)
  );

endmodule

// File: hdl/rsmvp_checker.sv
// Port-level checker for the rpm step map, bound to the top level.
`include "assert_macros.svh"

module rsmvp_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        full,
  input  logic        empty,
  input  logic        pop,
  input  logic [3:0]  out_chosen_index,
  input  logic [11:0] out_pulse_width_us
);
  import rsmvp_pkg::*;

  `CHK_ANY(a_reset_clears, !rst_n |=> empty && !full, "queues not clear after reset")
  `CHK_RUN(a_result_leaves_on_pop, $rose(empty) |-> $past(pop), "result dropped without pop")
  `CHK_RUN(a_index_in_table, !empty |-> out_chosen_index <= 4'(STEP_COUNT - 1), "index past table")
  `CHK_RUN(a_result_holds, !empty && !pop |=> !empty && $stable(out_pulse_width_us), "result changed while waiting")

endmodule

bind rpm_step_map_valve_position_top rsmvp_checker u_rsmvp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .full               (full),
  .empty              (empty),
  .pop                (pop),
  .out_chosen_index   (out_chosen_index),
  .out_pulse_width_us (out_pulse_width_us)
);

// File: tb/sv/tb.sv
// Testbench for the rpm step map valve position block: predicts each band lookup and checks it.
`timescale 1ns / 100ps

module tb;
  import rsmvp_pkg::*;

  localparam int STEPS = rsmvp_pkg::STEP_COUNT;

  typedef struct packed {
    logic [3:0]  chosen_index;
    logic [6:0]  open_percent;
    logic [11:0] pulse_width_us;
    logic        falling;
  } valve_pos_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        in_opcode = 1'b0;
  logic [3:0]  in_entry_index = '0;
  logic [15:0] in_entry_rpm = '0;
  logic [6:0]  in_entry_percent = '0;
  logic [15:0] in_engine_rpm = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [3:0]  out_chosen_index;
  logic [6:0]  out_open_percent;
  logic [11:0] out_pulse_width_us;
  logic        out_falling;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // band map copy kept by the testbench
  logic [15:0] band_rpm [STEPS];
  logic [6:0]  band_pct [STEPS];
  logic [15:0] last_chosen_rpm;
  logic        falling_state;
  logic [9:0]  hyst_rpm;
  logic [9:0]  margin_rpm;
  logic [11:0] closed_us;
  logic [11:0] open_us;

  valve_pos_t expected_positions[$];
  int         mismatch_count = 0;
  bit         idle_en = 1'b1;
  int         stall_left = 0;

  rpm_step_map_valve_position_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_opcode          (in_opcode),
    .in_entry_index     (in_entry_index),
    .in_entry_rpm       (in_entry_rpm),
    .in_entry_percent   (in_entry_percent),
    .in_engine_rpm      (in_engine_rpm),
    .empty              (empty),
    .pop                (pop),
    .out_chosen_index   (out_chosen_index),
    .out_open_percent   (out_open_percent),
    .out_pulse_width_us (out_pulse_width_us),
    .out_falling        (out_falling),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("ERROR at %0t: %s is %0d, predicted %0d", $time, what, got, want);
  endtask

  function automatic void reset_band_map();
    for (int k = 0; k < STEPS; k++) begin
      band_rpm[k] = 16'(3000 + (k * 3000) / (STEPS - 1));
      band_pct[k] = 7'((k * 100) / (STEPS - 1));
    end
    last_chosen_rpm = '0;
    falling_state   = 1'b0;
    hyst_rpm        = 10'd100;
    margin_rpm      = 10'd100;
    closed_us       = 12'd1300;
    open_us         = 12'd2400;
  endfunction

  function automatic void predict_valve_position(op_t op, logic [3:0] idx, logic [15:0] rpm,
                                                 logic [6:0] pct, logic [15:0] speed);
    int         offset;
    int         sel;
    int         pulse;
    valve_pos_t res;
    if (op == OP_LOAD) begin
      if (idx < STEPS) begin
        band_rpm[idx] = rpm;
        band_pct[idx] = pct;
      end
      return;
    end
    offset = falling_state ? int'(hyst_rpm) : 0;
    sel = 0;
    for (int k = 1; k < STEPS; k++) begin
      if (int'(speed) < int'(band_rpm[k]) - offset) begin
        sel = k - 1;
        break;
      end
    end
    if (int'(speed) >= int'(band_rpm[STEPS-1]) - int'(margin_rpm))
      sel = STEPS - 1;
    if (band_rpm[sel] < last_chosen_rpm)
      falling_state = 1'b1;
    else if (band_rpm[sel] > last_chosen_rpm)
      falling_state = 1'b0;
    last_chosen_rpm = band_rpm[sel];
    pulse = int'(closed_us) + (int'(band_pct[sel]) * (int'(open_us) - int'(closed_us))) / 100;
    if (pulse < 0)
      pulse = 0;
    if (pulse > 4095)
      pulse = 4095;
    res.chosen_index   = 4'(sel);
    res.open_percent   = band_pct[sel];
    res.pulse_width_us = 12'(pulse);
    res.falling        = falling_state;
    expected_positions.push_back(res);
  endfunction

  always @(posedge clk) begin : check_positions
    valve_pos_t want;
    if (rst_n && pop && !empty) begin
      if (expected_positions.size() == 0) begin
        report_mismatch("unexpected item, chosen_index", out_chosen_index, 0);
      end else begin
        want = expected_positions.pop_front();
        if (out_chosen_index !== want.chosen_index)
          report_mismatch("chosen_index", out_chosen_index, want.chosen_index);
        if (out_open_percent !== want.open_percent)
          report_mismatch("open_percent", out_open_percent, want.open_percent);
        if (out_pulse_width_us !== want.pulse_width_us)
          report_mismatch("pulse_width_us", out_pulse_width_us, want.pulse_width_us);
        if (out_falling !== want.falling)
          report_mismatch("falling", out_falling, want.falling);
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 9);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic send_item(op_t op, logic [3:0] idx, logic [15:0] rpm, logic [6:0] pct,
                           logic [15:0] speed);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    push             <= 1'b1;
    in_opcode        <= op;
    in_entry_index   <= idx;
    in_entry_rpm     <= rpm;
    in_entry_percent <= pct;
    in_engine_rpm    <= speed;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_valve_position(op, idx, rpm, pct, speed);
  endtask

  task automatic send_sample(logic [15:0] speed);
    send_item(OP_SAMPLE, 4'($urandom_range(0, 15)), 16'($urandom()),
              7'($urandom_range(0, 127)), speed);
  endtask

  task automatic send_load(logic [3:0] idx, logic [15:0] rpm, logic [6:0] pct);
    send_item(OP_LOAD, idx, rpm, pct, 16'($urandom()));
  endtask

  // hold off until every lookup has come back and trailing loads have drained
  task automatic wait_idle();
    push <= 1'b0;
    while (expected_positions.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(reg_t r, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (r)
      REG_HYST:   hyst_rpm   = value[9:0];
      REG_MARGIN: margin_rpm = value[9:0];
      REG_CLOSED: closed_us  = value[11:0];
      REG_OPEN:   open_us    = value[11:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] hyst, logic [31:0] margin, logic [31:0] closed,
                            logic [31:0] open);
    cfg_write(REG_HYST, hyst);
    cfg_write(REG_MARGIN, margin);
    cfg_write(REG_CLOSED, closed);
    cfg_write(REG_OPEN, open);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_reset_table_lookup();
    send_sample(16'd0);
    send_sample(16'd3000);
    send_sample(16'd3299);
    send_sample(16'hFFFF);
    send_sample(16'd4550);
    send_sample(16'd4450);
    send_sample(16'd4350);
    send_sample(16'd4420);
    send_sample(16'd5899);
    send_sample(16'd5900);
  endtask

  task automatic test_table_loads();
    send_load(4'd0, 16'hFFFF, 7'd127);
    send_load(4'd15, 16'd0, 7'd0);
    send_load(4'd11, 16'd1, 7'd1);
    send_load(4'd10, 16'h8000, 7'd0);
    send_load(4'd5, 16'd0, 7'd100);
    send_sample(16'd0);
    send_sample(16'd10000);
    send_sample(16'd4000);
    send_sample(16'h8000);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    set_config(32'd0, 32'd0, 32'd0, 32'd4095);
    send_sample(16'd0);
    send_sample(16'h7FFF);
    send_sample(16'hFFFF);
    wait_idle();
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_F000);
    send_sample(16'd0);
    send_sample(16'd4000);
    send_sample(16'h8000);
  endtask

  task automatic run_band_phase(int n_items);
    int base;
    int step;
    int pct;
    int walk;
    int span;
    int pick;
    base = $urandom_range(0, 30000);
    step = $urandom_range(30, 3000);
    pct  = $urandom_range(0, 20);
    for (int k = 0; k < STEPS; k++) begin
      send_load(4'(k), 16'(base + k * step), 7'(pct));
      pct = pct + $urandom_range(0, 12);
      if (pct > 127)
        pct = 127;
    end
    walk = base;
    span = step + 64;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_load(4'($urandom_range(0, 15)), 16'($urandom()), 7'($urandom_range(0, 127)));
      end else if (pick < 12) begin
        send_sample(16'($urandom()));
      end else begin
        if ($urandom_range(0, 15) == 0)
          walk = base + $urandom_range(0, STEPS - 1) * step;
        walk = walk + int'($urandom_range(0, 2 * span)) - span;
        if (walk < 0)
          walk = 0;
        if (walk > 65535)
          walk = 65535;
        send_sample(16'(walk));
      end
    end
  endtask

  task automatic test_random_bands(int n_phases, int n_items);
    for (int p = 0; p < n_phases; p++) begin
      wait_idle();
      case (p)
        0: set_config(32'd0, 32'd1023, 32'd4095, 32'd0);
        1: set_config(32'd1023, 32'd0, 32'd0, 32'd4095);
        2: set_config(32'd100, 32'd100, 32'd1300, 32'd2400);
        default: set_config($urandom(), $urandom(), $urandom(), $urandom());
      endcase
      run_band_phase(n_items);
    end
  endtask

  task automatic test_steady_stream(int n_items);
    wait_idle();
    idle_en = 1'b0;
    set_config($urandom(), $urandom(), $urandom(), $urandom());
    run_band_phase(n_items);
  endtask

  initial begin
    reset_band_map();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_table_lookup();
    test_table_loads();
    test_register_extremes();
    test_random_bands(7, 240);
    test_steady_stream(120);
    wait_idle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/rsmvp_pkg.sv
hdl/rsmvp_front.sv
hdl/rsmvp_back.sv
hdl/rpm_step_map_valve_position_top.sv
hdl/rsmvp_checker.sv
tb/sv/tb.sv
